[rtl/core/pprc_pkg.sv]
// ----------------------------------------------------------------------------
// Prefix port rule classifier package
// Shared constants, codes, the stored rule layout and helper functions.
// ----------------------------------------------------------------------------
package pprc_pkg;

   // Table geometry.
   localparam int RULE_DEPTH = 64;
   localparam int IDX_W      = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RULE_DEPTH + 1);

   // Request kinds.
   localparam logic KIND_INSERT   = 1'b0;
   localparam logic KIND_CLASSIFY = 1'b1;

   // Response status codes.
   localparam logic [1:0] STATUS_STORED  = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_MATCHED = 2'd2;
   localparam logic [1:0] STATUS_DEFAULT = 2'd3;

   // Longest legal prefix.
   localparam logic [5:0] MAX_PREFIX = 6'd32;

   // One stored rule as it sits in the rule memory.
   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  length;
      logic [1:0]  protocol;
      logic [15:0] port_low;
      logic [15:0] port_high;
      logic        action;
   } rule_entry_type;

   localparam int RULE_W = $bits(rule_entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic insert;
      logic classify;
      logic read;
      logic finish;
   } pprc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic scan_last;
   } pprc_stat_type;

   // Address mask for a prefix length; lengths of 32 and above keep every bit.
   function automatic logic [31:0] length_mask(input logic [5:0] len);
      logic [31:0] mask;
      if (len == 6'd0) begin
         mask = 32'h0;
      end else if (len >= MAX_PREFIX) begin
         mask = 32'hffff_ffff;
      end else begin
         mask = ~(32'hffff_ffff >> len);
      end
      return mask;
   endfunction

   // Low six bits of a table index for the response slot field.
   function automatic logic [5:0] slot_field(input logic [IDX_W-1:0] idx);
      logic [IDX_W+5:0] wide;
      wide = {6'b0, idx};
      return wide[5:0];
   endfunction

endpackage

[rtl/core/pprc_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pprc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pprc_datapath.sv]
// ----------------------------------------------------------------------------
// Prefix port rule classifier datapath
// Rule memory, fill count, scan index, match compare and response registers.
// ----------------------------------------------------------------------------
module pprc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  pprc_pkg::pprc_cmd_type cmd,
   output pprc_pkg::pprc_stat_type stat,
   input  logic [31:0]            req_address,
   input  logic [5:0]             req_prefix_length,
   input  logic [1:0]             req_protocol,
   input  logic [15:0]            req_port_low,
   input  logic [15:0]            req_port_high,
   input  logic [15:0]            req_packet_port,
   input  logic                   req_verdict_in,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic                   rsp_verdict,
   output logic [5:0]             rsp_rule_slot
);

   logic [pprc_pkg::CNT_W-1:0] count_ff, count_in;
   logic [pprc_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic                       cmp_vld_ff;
   logic [pprc_pkg::IDX_W-1:0] cmp_idx_ff;
   logic [31:0]                address_ff;
   logic [1:0]                 protocol_ff;
   logic [15:0]                port_ff;
   logic                       found_ff, found_in;
   logic [pprc_pkg::IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [5:0]                 best_len_ff, best_len_in;
   logic                       best_act_ff, best_act_in;
   logic                       rsp_valid_ff;
   logic [1:0]                 rsp_status_ff;
   logic                       rsp_verdict_ff;
   logic [5:0]                 rsp_slot_ff;

   logic                       full;
   logic                       wr_en;
   logic [5:0]                 len_sat;
   pprc_pkg::rule_entry_type   wr_entry;
   logic [pprc_pkg::RULE_W-1:0] rd_word;
   pprc_pkg::rule_entry_type   rd_entry;
   logic                       hit;

   // Fill state: slots below the count hold valid rules.
   assign full             = (count_ff == pprc_pkg::CNT_W'(pprc_pkg::RULE_DEPTH));
   assign stat.count_zero  = (count_ff == '0);
   assign stat.scan_last   = (pprc_pkg::CNT_W'(rd_idx_ff) == (count_ff - 1'b1));

   // Insert: saturate the length and store the masked prefix.
   assign len_sat = (req_prefix_length > pprc_pkg::MAX_PREFIX) ?
                    pprc_pkg::MAX_PREFIX : req_prefix_length;
   always_comb begin
      wr_entry.prefix    = req_address & pprc_pkg::length_mask(len_sat);
      wr_entry.length    = len_sat;
      wr_entry.protocol  = req_protocol;
      wr_entry.port_low  = req_port_low;
      wr_entry.port_high = req_port_high;
      wr_entry.action    = req_verdict_in;
   end
   assign wr_en    = cmd.insert && !full;
   assign count_in = wr_en ? (count_ff + 1'b1) : count_ff;

   pprc_ram #(
      .WIDTH(pprc_pkg::RULE_W),
      .DEPTH(pprc_pkg::RULE_DEPTH)
   ) u_rule_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[pprc_pkg::IDX_W-1:0]),
      .wr_data(wr_entry),
      .rd_en  (cmd.read),
      .rd_addr(rd_idx_ff),
      .rd_data(rd_word)
   );
   assign rd_entry = pprc_pkg::rule_entry_type'(rd_word);

   // Scan index advances by one slot per read.
   assign rd_idx_in = cmd.classify ? '0 :
                      (cmd.read ? (rd_idx_ff + 1'b1) : rd_idx_ff);

   // Match compare on the entry that came back from memory.
   assign hit = cmp_vld_ff
             && ((address_ff & pprc_pkg::length_mask(rd_entry.length)) == rd_entry.prefix)
             && (protocol_ff == rd_entry.protocol)
             && (port_ff >= rd_entry.port_low)
             && (port_ff <= rd_entry.port_high);

   // Best-rule update: strictly longer prefix wins, so the earlier slot keeps a tie.
   always_comb begin
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_len_in = best_len_ff;
      best_act_in = best_act_ff;
      if (cmd.classify) begin
         found_in = 1'b0;
      end else if (hit && (!found_ff || (rd_entry.length > best_len_ff))) begin
         found_in    = 1'b1;
         best_idx_in = cmp_idx_ff;
         best_len_in = rd_entry.length;
         best_act_in = rd_entry.action;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_vld_ff   <= cmd.read;
         found_ff     <= found_in;
         rsp_valid_ff <= cmd.insert || cmd.finish || (cmd.classify && stat.count_zero);
      end
   end

   // Payload registers: request capture, scan tracking and best rule.
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= rd_idx_ff;
      best_idx_ff <= best_idx_in;
      best_len_ff <= best_len_in;
      best_act_ff <= best_act_in;
      if (cmd.classify) begin
         address_ff  <= req_address;
         protocol_ff <= req_protocol;
         port_ff     <= req_packet_port;
      end
   end

   // Response registers.
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         rsp_status_ff  <= full ? pprc_pkg::STATUS_FULL : pprc_pkg::STATUS_STORED;
         rsp_verdict_ff <= 1'b0;
         rsp_slot_ff    <= full ? 6'd0 : pprc_pkg::slot_field(count_ff[pprc_pkg::IDX_W-1:0]);
      end else if (cmd.finish && found_in) begin
         rsp_status_ff  <= pprc_pkg::STATUS_MATCHED;
         rsp_verdict_ff <= best_act_in;
         rsp_slot_ff    <= pprc_pkg::slot_field(best_idx_in);
      end else if (cmd.finish || cmd.classify) begin
         rsp_status_ff  <= pprc_pkg::STATUS_DEFAULT;
         rsp_verdict_ff <= 1'b0;
         rsp_slot_ff    <= 6'd0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_verdict   = rsp_verdict_ff;
   assign rsp_rule_slot = rsp_slot_ff;

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pprc_pkg::CNT_W'(pprc_pkg::RULE_DEPTH))
      else $error("rule count exceeds table depth");

   // The final compare always has memory data behind it.
   a_finish_data: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> cmp_vld_ff)
      else $error("scan finished without a pending compare");

   // An insert into a full table answers full and leaves the count unchanged.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      cmd.insert && full |=> rsp_valid && (rsp_status == pprc_pkg::STATUS_FULL)
                             && (count_ff == $past(count_ff)))
      else $error("full table insert handled wrongly");

endmodule

[rtl/core/pprc_controller.sv]
// ----------------------------------------------------------------------------
// Prefix port rule classifier controller
// Accepts requests and sequences the rule scan of a classify request.
// ----------------------------------------------------------------------------
module pprc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_kind,
   output logic                    busy,
   output pprc_pkg::pprc_cmd_type  cmd,
   input  pprc_pkg::pprc_stat_type stat
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd.insert   = 1'b0;
      cmd.classify = 1'b0;
      cmd.read     = 1'b0;
      cmd.finish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == pprc_pkg::KIND_INSERT)) begin
               cmd.insert = 1'b1;
            end else if (accept) begin
               cmd.classify = 1'b1;
               if (!stat.count_zero) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The drain state always returns to idle in the next cycle.
   a_drain_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_IDLE))
      else $error("drain state did not return to idle");

   // A scan starts only with rules in the table.
   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.classify && stat.count_zero |=> (state_ff == ST_IDLE))
      else $error("scan started on an empty table");

   // Commands are mutually exclusive.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.insert, cmd.classify, cmd.read, cmd.finish}))
      else $error("more than one datapath command at once");

endmodule

[rtl/core/prefix_port_rule_classifier_core.sv]
// ----------------------------------------------------------------------------
// Prefix port rule classifier core
// Rule table with longest-prefix, protocol and port range classification.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  request   start, busy, req_*             taken when start is high, busy low
//  response  rsp_valid, rsp_*               one-cycle strobe, no backpressure
//
//  An insert answers in the cycle after it is taken; busy stays low.
//  A classify reads the rule memory one slot per cycle over the stored rules,
//  then makes the last compare in the drain state, with busy high until then
//  and the answer following as busy falls. A full table holds 64 rules.
//  A classify on an empty table answers on the next cycle.
//  Reset clears the fill count and control state, not the rule memory; no memory clearing pass is needed.
//  The response cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module prefix_port_rule_classifier_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_address,
   input  logic [5:0]  req_prefix_length,
   input  logic [1:0]  req_protocol,
   input  logic [15:0] req_port_low,
   input  logic [15:0] req_port_high,
   input  logic [15:0] req_packet_port,
   input  logic        req_verdict_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_verdict,
   output logic [5:0]  rsp_rule_slot
);

   pprc_pkg::pprc_cmd_type  cmd;
   pprc_pkg::pprc_stat_type stat;

   // Sequencer.
   pprc_controller u_controller (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_kind(req_kind),
      .busy    (busy),
      .cmd     (cmd),
      .stat    (stat)
   );

   // Rule storage and compare.
   pprc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_address      (req_address),
      .req_prefix_length(req_prefix_length),
      .req_protocol     (req_protocol),
      .req_port_low     (req_port_low),
      .req_port_high    (req_port_high),
      .req_packet_port  (req_packet_port),
      .req_verdict_in   (req_verdict_in),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_verdict      (rsp_verdict),
      .rsp_rule_slot    (rsp_rule_slot)
   );

endmodule
